/* rtl/half_step_stepper_positioner_macros.svh */
// Assertion macros for the half-step stepper positioner checker.
// Depends on nothing; the including scope provides clk and rst.
`ifndef HALF_STEP_STEPPER_POSITIONER_MACROS_SVH
`define HALF_STEP_STEPPER_POSITIONER_MACROS_SVH

// condition implies consequence in the same cycle
`define HSSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hssp assertion failed");

// condition implies consequence in the next cycle
`define HSSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hssp assertion failed");

`endif

/* rtl/hssp_pkg.sv */
// Shared types, constants and the half-step coil table for the stepper positioner.
// Depends on nothing.
package hssp_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int COIL_WIDTH         = 4;
  localparam int PHASE_WIDTH        = 3;
  localparam int TARGET_WIDTH       = 32;
  localparam int OUT_POS_WIDTH      = 32;

  // request function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  localparam logic [COIL_WIDTH-1:0] COILS_OFF = '0;

  typedef struct packed {
    logic [COIL_WIDTH-1:0]    coil_pins;
    logic [OUT_POS_WIDTH-1:0] position;
    logic                     target_reached;
    logic                     busy_res;
  } result_t;

  // 8-phase half-step pattern, A..D on bits 0..3
  function automatic logic [COIL_WIDTH-1:0] coil_pattern(input logic [PHASE_WIDTH-1:0] ph);
    logic [COIL_WIDTH-1:0] pat;
    unique case (ph)
      3'd0:    pat = 4'hE;
      3'd1:    pat = 4'hC;
      3'd2:    pat = 4'hD;
      3'd3:    pat = 4'h9;
      3'd4:    pat = 4'hB;
      3'd5:    pat = 4'h3;
      3'd6:    pat = 4'h7;
      default: pat = 4'h6;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/hssp_core.sv */
// Positioner state registers and the single-pass update for one request.
// Depends on hssp_pkg.
module hssp_core #(
  parameter int POSITION_WIDTH = hssp_pkg::POSITION_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              func,
  input  logic [hssp_pkg::TARGET_WIDTH-1:0] target_steps,
  output hssp_pkg::result_t                 res
);
  import hssp_pkg::*;

  localparam int EXT_WIDTH = POSITION_WIDTH + TARGET_WIDTH;

  logic [POSITION_WIDTH-1:0] step_position, step_position_next;
  logic [POSITION_WIDTH-1:0] goal_position, goal_position_next;
  logic                      moving, moving_next;
  logic                      arrived, arrived_next;
  logic                      forward, forward_next;
  logic [PHASE_WIDTH-1:0]    phase, phase_next;
  logic [COIL_WIDTH-1:0]     coil_levels, coil_levels_next;

  logic [EXT_WIDTH-1:0]      target_ext;
  logic [EXT_WIDTH-1:0]      pos_ext;
  logic [POSITION_WIDTH-1:0] target;

  // fit the target to the position width
  assign target_ext = {{POSITION_WIDTH{1'b0}}, target_steps};
  assign target     = target_ext[POSITION_WIDTH-1:0];

  // next state for the request at the input
  always_comb begin
    step_position_next = step_position;
    goal_position_next = goal_position;
    moving_next        = moving;
    arrived_next       = arrived;
    forward_next       = forward;
    phase_next         = phase;
    coil_levels_next   = coil_levels;
    if (func == FUNC_MOVE) begin
      goal_position_next = target;
      if (target != step_position) begin
        forward_next = target > step_position;
        moving_next  = 1'b1;
        arrived_next = 1'b0;
      end else begin
        if (moving) begin
          coil_levels_next = COILS_OFF;
        end
        moving_next  = 1'b0;
        arrived_next = 1'b1;
      end
    end else if (moving) begin
      coil_levels_next = coil_pattern(phase);
      if (forward) begin
        phase_next         = phase + PHASE_WIDTH'(1);
        step_position_next = step_position + POSITION_WIDTH'(1);
      end else begin
        phase_next         = phase - PHASE_WIDTH'(1);
        step_position_next = step_position - POSITION_WIDTH'(1);
      end
      if (step_position_next == goal_position) begin
        arrived_next     = 1'b1;
        moving_next      = 1'b0;
        coil_levels_next = COILS_OFF;
      end else begin
        arrived_next = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_position <= '0;
      goal_position <= '0;
      moving        <= 1'b0;
      arrived       <= 1'b1;
      forward       <= 1'b0;
      phase         <= '0;
      coil_levels   <= COILS_OFF;
    end else if (accept) begin
      step_position <= step_position_next;
      goal_position <= goal_position_next;
      moving        <= moving_next;
      arrived       <= arrived_next;
      forward       <= forward_next;
      phase         <= phase_next;
      coil_levels   <= coil_levels_next;
    end
  end

  // result reported after the update
  assign pos_ext            = {{TARGET_WIDTH{1'b0}}, step_position_next};
  assign res.coil_pins      = coil_levels_next;
  assign res.position       = pos_ext[OUT_POS_WIDTH-1:0];
  assign res.target_reached = arrived_next;
  assign res.busy_res       = moving_next;

endmodule

/* rtl/hssp_outbuf.sv */
// Two-entry result buffer: an output register with a skid stage behind it.
// Depends on hssp_pkg.
module hssp_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hssp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output hssp_pkg::result_t out_data
);
  import hssp_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

/* rtl/half_step_stepper_positioner.sv */
// Half-step stepper positioner: a move request sets an absolute target, each tick
// request advances one half step toward it and reports coils, position and status.
// One request is taken every clock cycle unless in_stall is raised; its result is
// registered in the result buffer. The position and phase registers update in the
// cycle of the request, and a two-entry result buffer lets requests keep entering
// while a result waits, so stall is raised only when both entries hold.
// Depends on hssp_pkg, hssp_core and hssp_outbuf.
module half_step_stepper_positioner #(
  parameter int POSITION_WIDTH = hssp_pkg::POSITION_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [hssp_pkg::TARGET_WIDTH-1:0]  target_steps,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hssp_pkg::COIL_WIDTH-1:0]    coil_pins,
  output logic [hssp_pkg::OUT_POS_WIDTH-1:0] position,
  output logic                               target_reached,
  output logic                               busy_res
);
  import hssp_pkg::*;

  logic    accept;
  logic    full;
  result_t res;
  result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // state update
  hssp_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (func),
    .target_steps (target_steps),
    .res          (res)
  );

  // result buffering
  hssp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign coil_pins      = out_data.coil_pins;
  assign position       = out_data.position;
  assign target_reached = out_data.target_reached;
  assign busy_res       = out_data.busy_res;

endmodule

/* rtl/hssp_chk.sv */
// Port-level checker for the stepper positioner, bound to the top level.
// Depends on hssp_pkg and half_step_stepper_positioner_macros.svh.
`include "half_step_stepper_positioner_macros.svh"

module hssp_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [hssp_pkg::COIL_WIDTH-1:0]    coil_pins,
  input logic [hssp_pkg::OUT_POS_WIDTH-1:0] position,
  input logic                               target_reached,
  input logic                               busy_res
);
  import hssp_pkg::*;

  logic [2:0] coil_ones;
  logic       coil_count_ok;

  // number of energized coils in the offered pattern
  assign coil_ones     = 3'($countones(coil_pins));
  assign coil_count_ok = (coil_ones == 3'd2) || (coil_ones == 3'd3);

  // a stalled result stays offered
  `HSSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // input stall only while a result is offered
  `HSSP_ASSERT_NOW(a_stall_full, in_stall, out_valid)

  // reached and busy are always opposite
  `HSSP_ASSERT_NOW(a_reached_busy, out_valid, target_reached != busy_res)

  // coils are released whenever no move runs
  `HSSP_ASSERT_NOW(a_idle_coils, out_valid && !busy_res, coil_pins == COILS_OFF)

  // a driven half-step pattern energizes two or three coils
  `HSSP_ASSERT_NOW(a_coil_count, out_valid && coil_pins != COILS_OFF, coil_count_ok)

endmodule

bind half_step_stepper_positioner hssp_chk u_hssp_chk (.*);

/* sim/testbench.sv */
// Self-checking bench for the half-step stepper positioner: move and tick requests,
// a predicted copy of position, phase and coil state, and random idling on both sides.
// Depends on hssp_pkg and half_step_stepper_positioner.
module testbench;
  import hssp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LATE_ITEMS   = 1800;
  localparam int LONG_HOLD    = 60;
  localparam int CYCLE_LIMIT  = 400000;

  // predicted positioner state and the results it still owes
  class positioner_tracker;
    logic [OUT_POS_WIDTH-1:0] cur_pos;
    logic [OUT_POS_WIDTH-1:0] goal_pos;
    logic                     in_motion;
    logic                     at_goal;
    logic                     heading_up;
    logic [PHASE_WIDTH-1:0]   phase_idx;
    logic [COIL_WIDTH-1:0]    coil_drive;
    logic [COIL_WIDTH-1:0]    half_step_seq [8];
    result_t                  owed_results [$];
    int                       errors;

    function new();
      cur_pos       = '0;
      goal_pos      = '0;
      in_motion     = 1'b0;
      at_goal       = 1'b1;
      heading_up    = 1'b0;
      phase_idx     = '0;
      coil_drive    = COILS_OFF;
      half_step_seq = '{4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3, 4'h7, 4'h6};
      errors        = 0;
    endfunction

    // advance the predicted state by one accepted request
    function void take_request(logic f, logic [TARGET_WIDTH-1:0] t);
      result_t res;
      if (f == FUNC_MOVE) begin
        if (t != cur_pos) begin
          heading_up = (t > cur_pos);
          in_motion  = 1'b1;
          at_goal    = 1'b0;
        end else begin
          if (in_motion) coil_drive = COILS_OFF;
          in_motion = 1'b0;
          at_goal   = 1'b1;
        end
        goal_pos = t;
      end else if (in_motion) begin
        coil_drive = half_step_seq[phase_idx];
        if (heading_up) begin
          phase_idx = phase_idx + 3'd1;
          cur_pos   = cur_pos + 32'd1;
        end else begin
          phase_idx = phase_idx - 3'd1;
          cur_pos   = cur_pos - 32'd1;
        end
        if (cur_pos == goal_pos) begin
          at_goal    = 1'b1;
          in_motion  = 1'b0;
          coil_drive = COILS_OFF;
        end else begin
          at_goal = 1'b0;
        end
      end
      res.coil_pins      = coil_drive;
      res.position       = cur_pos;
      res.target_reached = at_goal;
      res.busy_res       = in_motion;
      owed_results.push_back(res);
    endfunction

    // compare one delivered result with the oldest owed one
    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: coil_pins %h position %h", got.coil_pins,
               got.position);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.coil_pins !== want.coil_pins) begin
        $error("coil_pins expected %h actual %h", want.coil_pins, got.coil_pins);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position expected %h actual %h", want.position, got.position);
        errors++;
      end
      if (got.target_reached !== want.target_reached) begin
        $error("target_reached expected %b actual %b", want.target_reached,
               got.target_reached);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res expected %b actual %b", want.busy_res, got.busy_res);
        errors++;
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     func;
  logic [TARGET_WIDTH-1:0]  target_steps;
  logic                     out_valid;
  logic                     out_stall;
  logic [COIL_WIDTH-1:0]    coil_pins;
  logic [OUT_POS_WIDTH-1:0] position;
  logic                     target_reached;
  logic                     busy_res;

  positioner_tracker tracker = new();

  int  sent_count;
  int  sender_calm;
  int  rcv_calm;
  bit  late_phase;
  bit  long_hold_req;
  bit  long_hold_done;
  int  pick;
  int  base_count;
  logic [TARGET_WIDTH-1:0] tgt;

  half_step_stepper_positioner uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .target_steps   (target_steps),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .coil_pins      (coil_pins),
    .position       (position),
    .target_reached (target_reached),
    .busy_res       (busy_res)
  );

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("half_step_stepper_positioner verification failed");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result('{coil_pins, position, target_reached, busy_res});
  end

  // receiver stall: bursts, quiet stretches and one long hold
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (late_phase || rcv_calm > 0) begin
        if (rcv_calm > 0) rcv_calm--;
      end else if ($urandom_range(0, 29) == 0) begin
        rcv_calm = $urandom_range(30, 150);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // drop valid for a while
  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // offer one request and hold it until taken
  task automatic send_request(input logic f, input logic [TARGET_WIDTH-1:0] t);
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (!late_phase) begin
      if ($urandom_range(0, 39) == 0) sender_calm = $urandom_range(20, 60);
      else if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 19));
    end
    in_valid     <= 1'b1;
    func         <= f;
    target_steps <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_request(f, t);
    sent_count++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(FUNC_TICK, $urandom());
  endtask

  // hold off the sender until every result is in
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  // ticks still needed to reach the goal, capped for far targets
  function automatic int steps_left();
    logic [OUT_POS_WIDTH-1:0] gap;
    if (!tracker.in_motion) return 0;
    gap = tracker.heading_up ? tracker.goal_pos - tracker.cur_pos
                             : tracker.cur_pos - tracker.goal_pos;
    return (gap > 45) ? 45 : int'(gap);
  endfunction

  // a target a short way up or down from the present position
  function automatic logic [TARGET_WIDTH-1:0] near_target();
    int unsigned off;
    off = $urandom_range(1, 40);
    return $urandom_range(0, 1) ? tracker.cur_pos + off : tracker.cur_pos - off;
  endfunction

  // stimulus
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = FUNC_TICK;
    target_steps = '0;
    sent_count   = 0;
    sender_calm  = 0;
    rcv_calm     = 0;
    late_phase   = 1'b0;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, move to current spot, full phase cycle, reversals
    send_request(FUNC_TICK, 32'hFFFF_FFFF);
    send_request(FUNC_MOVE, 32'h0000_0000);
    send_request(FUNC_MOVE, 32'd10);
    send_ticks(10);
    send_request(FUNC_TICK, 32'h0000_0000);
    send_request(FUNC_MOVE, 32'd3);
    send_ticks(2);
    send_request(FUNC_MOVE, 32'd12);
    send_ticks(1);
    send_request(FUNC_MOVE, tracker.cur_pos);
    send_request(FUNC_MOVE, 32'hFFFF_FFFF);
    send_ticks(1);
    send_request(FUNC_MOVE, 32'h8000_0000);
    send_ticks(1);
    send_request(FUNC_MOVE, tracker.cur_pos);
    drain_results();

    // random sequences, mostly well-formed approaches
    base_count = sent_count;
    while (sent_count - base_count < RANDOM_ITEMS) begin
      if (sent_count - base_count >= LATE_ITEMS) late_phase = 1'b1;
      if (!long_hold_done && sent_count - base_count >= 500) begin
        // receiver holds off while requests keep coming
        long_hold_done = 1'b1;
        long_hold_req  = 1'b1;
        sender_calm    = 40;
        send_request(FUNC_MOVE, near_target());
        send_ticks(20);
      end
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        send_request(FUNC_MOVE, near_target());
        send_ticks(steps_left() + $urandom_range(0, 2));
      end else if (pick < 12) begin
        // retarget partway through a move
        send_request(FUNC_MOVE, near_target());
        send_ticks(steps_left() / 2);
        send_request(FUNC_MOVE, near_target());
        send_ticks(steps_left() + $urandom_range(0, 1));
      end else if (pick < 14) begin
        // far target, then stop where it stands
        send_request(FUNC_MOVE, $urandom());
        send_ticks($urandom_range(1, 12));
        send_request(FUNC_MOVE, tracker.cur_pos);
      end else if (pick == 14) begin
        send_request(FUNC_MOVE, tracker.cur_pos);
        send_ticks($urandom_range(1, 4));
      end else if (pick < 17) begin
        // noise
        repeat ($urandom_range(1, 8)) begin
          tgt = $urandom();
          send_request($urandom_range(0, 1) ? FUNC_MOVE : FUNC_TICK, tgt);
        end
      end else if (pick == 17 && !late_phase && $urandom_range(0, 3) == 0) begin
        drain_results();
      end else begin
        send_ticks($urandom_range(1, 5));
      end
    end

    // wait out the remaining results
    in_valid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed() == 0)
      $display("half_step_stepper_positioner verification clean");
    else
      $display("half_step_stepper_positioner verification failed");
    $finish;
  end

endmodule
